// File: rtl/core/gbt_pkg.sv
// Shared types and codes for the gap buffer text engine.
package gbt_pkg;

    // Request codes carried in req_type.
    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_DELETE = 3'd1;
    localparam logic [2:0] REQ_MOVE   = 3'd2;
    localparam logic [2:0] REQ_READ   = 3'd3;
    localparam logic [2:0] REQ_NEXT   = 3'd4;
    localparam logic [2:0] REQ_PREV   = 3'd5;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [7:0]         data_char;
        logic signed [11:0] shift_count;
        logic [9:0]         position;
    } gbt_req_t;

    typedef struct packed {
        logic [7:0]  char_out;
        logic [1:0]  status;
        logic [10:0] text_length;
        logic [10:0] gap_index;
    } gbt_rsp_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_EVAL,
        SEQ_MOVE,
        SEQ_DRAIN,
        SEQ_RDATA,
        SEQ_DONE
    } gbt_state_t;

endpackage

// File: rtl/core/gbt_text_ram.sv
// Text byte store: one write port, one registered read port.
module gbt_text_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/gbt_seq.sv
// Request sequencer: gap pointers, iterator, range checks and byte-copy loop.
module gbt_seq #(
    parameter int BUFFER_BYTES = 1024,
    parameter int AW           = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             req_valid,
    input  gbt_pkg::gbt_req_t req_in,
    output logic             req_ready,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output gbt_pkg::gbt_rsp_t rsp_out,
    output logic             ram_wr_en,
    output logic [AW-1:0]    ram_wr_addr,
    output logic [7:0]       ram_wr_data,
    output logic             ram_rd_en,
    output logic [AW-1:0]    ram_rd_addr,
    input  logic [7:0]       ram_rd_data
);

    import gbt_pkg::*;

    localparam int PW = $clog2(BUFFER_BYTES + 1);
    localparam int WW = ((PW > 12) ? PW : 12) + 1;
    localparam logic [WW-1:0] BUF_W = WW'(BUFFER_BYTES);

    gbt_state_t    state_reg, state_next;
    gbt_req_t      req_reg, req_next;
    logic [PW-1:0] gs_reg, gs_next;
    logic [PW-1:0] ge_reg, ge_next;
    logic [AW-1:0] iter_reg, iter_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic          dir_reg, dir_next;      // 1: gap moves toward the end
    logic          wr_pend_reg, wr_pend_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic [1:0]    status_reg, status_next;
    logic [7:0]    char_reg, char_next;

    // Evaluation datapath
    logic signed [WW-1:0] cnt_s;
    logic        [WW-1:0] mag, gs_w, ge_w, len_w, pos_w, iter_w, idx_w, phys_w;
    logic                 cnt_neg, fits, idx_bad;
    logic [PW-1:0]        gs_inc, ge_inc, gs_dec, ge_dec;

    always_comb begin
        cnt_s   = WW'(req_reg.shift_count);
        cnt_neg = cnt_s < 0;
        mag     = cnt_neg ? WW'(-cnt_s) : WW'(cnt_s);
        gs_w    = WW'(gs_reg);
        ge_w    = WW'(ge_reg);
        len_w   = gs_w + BUF_W - ge_w;
        fits    = cnt_neg ? (mag <= gs_w) : ((ge_w + mag) <= BUF_W);
        pos_w   = WW'(req_reg.position);
        iter_w  = WW'(iter_reg);
        idx_w   = pos_w;
        idx_bad = 1'b1;
        case (req_reg.req_type)
            REQ_READ: begin
                idx_w   = pos_w;
                idx_bad = pos_w >= len_w;
            end
            REQ_NEXT: begin
                idx_w   = iter_w + WW'(1);
                idx_bad = idx_w >= len_w;
            end
            REQ_PREV: begin
                idx_w   = iter_w - WW'(1);
                idx_bad = (iter_w == '0) || (idx_w >= len_w);
            end
            default: begin
                idx_w   = pos_w;
                idx_bad = 1'b1;
            end
        endcase
        phys_w = (idx_w < gs_w) ? idx_w : (ge_w + idx_w - gs_w);
        gs_inc = gs_reg + PW'(1);
        ge_inc = ge_reg + PW'(1);
        gs_dec = gs_reg - PW'(1);
        ge_dec = ge_reg - PW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SEQ_IDLE;
            gs_reg      <= '0;
            ge_reg      <= PW'(BUFFER_BYTES);
            iter_reg    <= '0;
            wr_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gs_reg      <= gs_next;
            ge_reg      <= ge_next;
            iter_reg    <= iter_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        cnt_reg     <= cnt_next;
        dir_reg     <= dir_next;
        wr_addr_reg <= wr_addr_next;
        status_reg  <= status_next;
        char_reg    <= char_next;
    end

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        gs_next      = gs_reg;
        ge_next      = ge_reg;
        iter_next    = iter_reg;
        cnt_next     = cnt_reg;
        dir_next     = dir_reg;
        wr_pend_next = wr_pend_reg;
        wr_addr_next = wr_addr_reg;
        status_next  = status_reg;
        char_next    = char_reg;
        req_ready    = 1'b0;
        rsp_valid    = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = wr_addr_reg;
        ram_wr_data  = ram_rd_data;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = phys_w[AW-1:0];

        case (state_reg)
            SEQ_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    req_next   = req_in;
                    state_next = SEQ_EVAL;
                end
            end
            SEQ_EVAL: begin
                status_next = STATUS_OK;
                char_next   = 8'd0;
                state_next  = SEQ_DONE;
                case (req_reg.req_type)
                    REQ_INSERT: begin
                        if (gs_reg >= ge_reg) begin
                            status_next = STATUS_FULL;
                        end else begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = gs_reg[AW-1:0];
                            ram_wr_data = req_reg.data_char;
                            gs_next     = gs_inc;
                        end
                    end
                    REQ_DELETE: begin
                        if (!fits) begin
                            status_next = STATUS_RANGE;
                        end else if (cnt_neg) begin
                            gs_next = gs_reg - PW'(mag);
                        end else begin
                            ge_next = ge_reg + PW'(mag);
                        end
                    end
                    REQ_MOVE: begin
                        if (!fits) begin
                            status_next = STATUS_RANGE;
                        end else if (mag != '0) begin
                            cnt_next     = PW'(mag);
                            dir_next     = !cnt_neg;
                            wr_pend_next = 1'b0;
                            state_next   = SEQ_MOVE;
                        end
                    end
                    REQ_READ, REQ_NEXT, REQ_PREV: begin
                        if (idx_bad) begin
                            status_next = STATUS_RANGE;
                        end else begin
                            iter_next  = idx_w[AW-1:0];
                            ram_rd_en  = 1'b1;
                            state_next = SEQ_RDATA;
                        end
                    end
                    default: begin
                        status_next = STATUS_RANGE;
                    end
                endcase
            end
            SEQ_MOVE: begin
                // Read one byte across the gap, write the byte read last cycle.
                ram_wr_en    = wr_pend_reg;
                ram_rd_en    = 1'b1;
                wr_pend_next = 1'b1;
                cnt_next     = cnt_reg - PW'(1);
                if (dir_reg) begin
                    ram_rd_addr  = ge_reg[AW-1:0];
                    wr_addr_next = gs_reg[AW-1:0];
                    gs_next      = gs_inc;
                    ge_next      = ge_inc;
                end else begin
                    ram_rd_addr  = gs_dec[AW-1:0];
                    wr_addr_next = ge_dec[AW-1:0];
                    gs_next      = gs_dec;
                    ge_next      = ge_dec;
                end
                if (cnt_reg == PW'(1)) begin
                    state_next = SEQ_DRAIN;
                end
            end
            SEQ_DRAIN: begin
                ram_wr_en    = wr_pend_reg;
                wr_pend_next = 1'b0;
                state_next   = SEQ_DONE;
            end
            SEQ_RDATA: begin
                char_next  = ram_rd_data;
                state_next = SEQ_DONE;
            end
            SEQ_DONE: begin
                rsp_valid = 1'b1;
                if (rsp_ready) begin
                    state_next = SEQ_IDLE;
                end
            end
            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_comb begin
        rsp_out.char_out    = char_reg;
        rsp_out.status      = status_reg;
        rsp_out.text_length = 11'(len_w);
        rsp_out.gap_index   = 11'(gs_reg);
    end

endmodule

// File: rtl/core/gap_buffer_text_engine.sv
// Gap buffer text engine: top level with sequencer, text store and result register.
// Sequencer path: insert, delete, zero move and flagged requests go evaluate, done; read and
//   iterator steps go evaluate, read data, done; a gap move of n bytes goes evaluate, move, drain, done.
// Throughput: one request at a time, the next taken only once the last result leaves the sequencer;
//   a gap move copies one byte per cycle, and a result held by m_ready delays the next finish.
// Reset (aresetn, sync, active low): empty text, full-store gap, iterator 0, store not cleared.
module gap_buffer_text_engine #(
    parameter int BUFFER_BYTES = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gbt_pkg::gbt_req_t s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output gbt_pkg::gbt_rsp_t m_payload
);

    import gbt_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);

    // Sequencer <-> result register
    logic     rsp_valid;
    logic     rsp_ready;
    gbt_rsp_t rsp_data;

    // Sequencer <-> text store
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;

    // Output register state
    logic     m_valid_reg, m_valid_next;
    gbt_rsp_t m_payload_reg, m_payload_next;

    // The sequencer owns the gap pointers and the iterator. It takes a new
    // request only from its idle state, so s_ready drops for the whole of a
    // request, including the byte-by-byte copy of a gap move.
    gbt_seq #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .AW           (AW)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_valid),
        .req_in      (s_payload),
        .req_ready   (s_ready),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_out     (rsp_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // Physical byte store. Bytes in front of the gap sit at their logical
    // index; bytes behind it are packed against the top of the store.
    gbt_text_ram #(
        .DEPTH (BUFFER_BYTES),
        .AW    (AW)
    ) u_text_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Result register: a finished result moves here so the sequencer can
    // return to idle and take the next request while this one waits for
    // its transfer on the m_ side.
    always_comb begin
        rsp_ready      = !m_valid_reg || m_ready;
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        if (rsp_ready) begin
            m_valid_next = rsp_valid;
            if (rsp_valid) begin
                m_payload_next = rsp_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

// File: tb/sv/gap_buffer_text_engine_tb.sv
// Self-checking bench for the gap buffer text engine: scripted edits, then a long random mix.
`timescale 1ns / 100ps

module gap_buffer_text_engine_tb;
    import gbt_pkg::*;

    localparam int BYTES        = 1024;
    localparam int EDITS_RANDOM = 900;
    localparam int FILL_AT      = 450;   // random edit index where the store is filled to the brim
    localparam int CALM_AT      = 200;   // extra hold-off until all replies are back
    localparam int QUIET_LIMIT  = 6000;  // watchdog limit, well above a full-span gap move on its own
    localparam int TAIL_CYCLES  = 16;

    // Request codes the block does not define; both must be flagged.
    localparam logic [2:0] REQ_UNKNOWN_6 = 3'd6;
    localparam logic [2:0] REQ_UNKNOWN_7 = 3'd7;

    // One scripted edit. When 'typed' is set the reply is the one written in the row;
    // otherwise the reply comes from the text model below.
    typedef struct packed {
        gbt_req_t req;
        logic     typed;
        gbt_rsp_t want;
    } script_row_t;

    localparam script_row_t SCRIPT [25] = '{
        // empty text: every range check trips, zero counts pass
        '{'{REQ_READ,      8'h00,  12'sd0,    10'h3FF}, 1'b1, '{8'h00, STATUS_RANGE, 11'd0, 11'd0}},
        '{'{REQ_NEXT,      8'h00,  12'sd0,    10'h000}, 1'b1, '{8'h00, STATUS_RANGE, 11'd0, 11'd0}},
        '{'{REQ_PREV,      8'h00,  12'sd0,    10'h000}, 1'b1, '{8'h00, STATUS_RANGE, 11'd0, 11'd0}},
        '{'{REQ_DELETE,    8'h00, -12'sd1024, 10'h000}, 1'b1, '{8'h00, STATUS_RANGE, 11'd0, 11'd0}},
        '{'{REQ_DELETE,    8'h00,  12'sd1024, 10'h000}, 1'b1, '{8'h00, STATUS_RANGE, 11'd0, 11'd0}},
        '{'{REQ_MOVE,      8'h00, -12'sd1024, 10'h000}, 1'b1, '{8'h00, STATUS_RANGE, 11'd0, 11'd0}},
        '{'{REQ_MOVE,      8'h00,  12'sd1024, 10'h000}, 1'b1, '{8'h00, STATUS_RANGE, 11'd0, 11'd0}},
        '{'{REQ_DELETE,    8'h00,  12'sd0,    10'h000}, 1'b1, '{8'h00, STATUS_OK,    11'd0, 11'd0}},
        '{'{REQ_MOVE,      8'h00,  12'sd0,    10'h000}, 1'b1, '{8'h00, STATUS_OK,    11'd0, 11'd0}},
        '{'{REQ_UNKNOWN_6, 8'h00,  12'sd0,    10'h000}, 1'b1, '{8'h00, STATUS_RANGE, 11'd0, 11'd0}},
        '{'{REQ_UNKNOWN_7, 8'hFF, -12'sd1,    10'h3FF}, 1'b1, '{8'h00, STATUS_RANGE, 11'd0, 11'd0}},
        // first bytes: extremes of data_char
        '{'{REQ_INSERT,    8'h00,  12'sd0,    10'h000}, 1'b1, '{8'h00, STATUS_OK,    11'd1, 11'd1}},
        '{'{REQ_INSERT,    8'hFF,  12'sd0,    10'h000}, 1'b1, '{8'h00, STATUS_OK,    11'd2, 11'd2}},
        '{'{REQ_INSERT,    8'hA5,  12'sd0,    10'h000}, 1'b0, '0},
        '{'{REQ_INSERT,    8'h5A,  12'sd0,    10'h000}, 1'b0, '0},
        // gap to the front, then walk the iterator off the far end and back
        '{'{REQ_MOVE,      8'h00, -12'sd4,    10'h000}, 1'b0, '0},
        '{'{REQ_READ,      8'h00,  12'sd0,    10'h003}, 1'b0, '0},
        '{'{REQ_NEXT,      8'h00,  12'sd0,    10'h000}, 1'b0, '0},
        '{'{REQ_PREV,      8'h00,  12'sd0,    10'h000}, 1'b0, '0},
        // gap into the middle; reads must skip it
        '{'{REQ_MOVE,      8'h00,  12'sd2,    10'h000}, 1'b0, '0},
        '{'{REQ_READ,      8'h00,  12'sd0,    10'h003}, 1'b0, '0},
        // delete after the gap leaves the iterator past the end of the text
        '{'{REQ_DELETE,    8'h00,  12'sd1,    10'h000}, 1'b0, '0},
        '{'{REQ_NEXT,      8'h00,  12'sd0,    10'h000}, 1'b0, '0},
        '{'{REQ_PREV,      8'h00,  12'sd0,    10'h000}, 1'b0, '0},
        '{'{REQ_DELETE,    8'h00, -12'sd1,    10'h000}, 1'b0, '0}
    };

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    gbt_req_t s_payload;
    logic     m_valid;
    logic     m_ready = 1'b0;
    gbt_rsp_t m_payload;

    // Text model: store, gap edges (physical) and the read iterator (logical).
    logic [7:0] text_mem [BYTES];
    int         gap_lo  = 0;
    int         gap_hi  = BYTES;
    int         iter_at = 0;

    gbt_rsp_t edit_replies [$];  // replies owed by the block, oldest first

    int  mismatches = 0;
    int  quiet_cycles = 0;
    int  stall_left = 0;
    int  req_seen [8];
    int  status_seen [4];
    bit  steady_tx = 1'b0;  // sender never idles while set
    bit  steady_rx = 1'b0;  // receiver never stalls while set

    gap_buffer_text_engine #(
        .BUFFER_BYTES(BYTES)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    always #4 aclk = ~aclk;

    function automatic int text_len();
        return gap_lo + BYTES - gap_hi;
    endfunction

    // Logical index to byte, stepping over the gap.
    function automatic logic [7:0] char_at(int idx);
        int phys;
        phys = (idx < gap_lo) ? idx : gap_hi + idx - gap_lo;
        return (phys >= BYTES) ? 8'h00 : text_mem[phys];
    endfunction

    // Applies one edit to the text model and returns the reply the block owes for it.
    function automatic gbt_rsp_t apply_edit(gbt_req_t r);
        gbt_rsp_t o;
        int       cnt;
        int       n;
        int       len;
        int       i;
        bit       fits;
        o        = '0;
        o.status = STATUS_OK;
        cnt      = $signed(r.shift_count);
        n        = (cnt < 0) ? -cnt : cnt;
        len      = text_len();
        fits     = (cnt < 0) ? (n <= gap_lo) : (gap_hi + n <= BYTES);
        case (r.req_type)
            REQ_INSERT: begin
                if (gap_lo >= gap_hi) begin
                    o.status = STATUS_FULL;
                end else begin
                    text_mem[gap_lo] = r.data_char;
                    gap_lo++;
                end
            end
            REQ_DELETE: begin
                if (!fits) begin
                    o.status = STATUS_RANGE;
                end else if (cnt < 0) begin
                    gap_lo -= n;
                end else begin
                    gap_hi += n;
                end
            end
            REQ_MOVE: begin
                if (!fits) begin
                    o.status = STATUS_RANGE;
                end else if (cnt < 0) begin
                    gap_lo -= n;
                    gap_hi -= n;
                    // bytes move up across the gap; copy top down in case the spans overlap
                    for (i = n - 1; i >= 0; i--) text_mem[gap_hi + i] = text_mem[gap_lo + i];
                end else begin
                    for (i = 0; i < n; i++) text_mem[gap_lo + i] = text_mem[gap_hi + i];
                    gap_lo += n;
                    gap_hi += n;
                end
            end
            REQ_READ: begin
                if (r.position >= len) begin
                    o.status = STATUS_RANGE;
                end else begin
                    iter_at    = r.position;
                    o.char_out = char_at(iter_at);
                end
            end
            REQ_NEXT: begin
                if (iter_at + 1 >= len) begin
                    o.status = STATUS_RANGE;
                end else begin
                    iter_at++;
                    o.char_out = char_at(iter_at);
                end
            end
            REQ_PREV: begin
                // iterator is never moved by deletes, so it can sit past the end
                if (iter_at == 0 || iter_at - 1 >= len) begin
                    o.status = STATUS_RANGE;
                end else begin
                    iter_at--;
                    o.char_out = char_at(iter_at);
                end
            end
            default: o.status = STATUS_RANGE;
        endcase
        o.text_length = 11'(text_len());
        o.gap_index   = 11'(gap_lo);
        return o;
    endfunction

    // Mostly short pauses, now and then a long one.
    function automatic int pause_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Signed count that keeps the gap inside the store, magnitude at most cap.
    function automatic int fit_count(int cap);
        int back;
        int ahead;
        back  = gap_lo;
        ahead = BYTES - gap_hi;
        if (back == 0 && ahead == 0) return 0;
        if (ahead == 0 || (back > 0 && $urandom_range(0, 1) == 1))
            return -$urandom_range(1, (back < cap) ? back : cap);
        return $urandom_range(1, (ahead < cap) ? ahead : cap);
    endfunction

    // Next random edit, shaped by the current text so most requests land in range.
    // Fields the request ignores still carry random bits.
    function automatic gbt_req_t pick_edit();
        gbt_req_t r;
        int       dice;
        int       roll;
        int       len;
        len           = text_len();
        r.req_type    = REQ_INSERT;
        r.data_char   = 8'($urandom);
        r.shift_count = 12'(int'($urandom_range(0, 2 * BYTES)) - BYTES);
        r.position    = 10'($urandom);
        dice          = $urandom_range(0, 99);
        if (len < 8 && dice < 50) dice = 0;  // short text: grow it first
        roll = $urandom_range(0, 19);
        if (dice < 34) begin
            r.req_type = REQ_INSERT;
        end else if (dice < 46) begin
            r.req_type = REQ_DELETE;
            if (roll < 18) r.shift_count = 12'(fit_count(4));
        end else if (dice < 60) begin
            r.req_type = REQ_MOVE;
            if (roll < 17) r.shift_count = 12'(fit_count(16));
            else if (roll < 19) r.shift_count = 12'(fit_count(BYTES));
        end else if (dice < 74) begin
            r.req_type = REQ_READ;
            if (len > 0 && roll < 17) r.position = 10'($urandom_range(0, len - 1));
        end else if (dice < 87) begin
            r.req_type = REQ_NEXT;
        end else if (dice < 98) begin
            r.req_type = REQ_PREV;
        end else begin
            r.req_type = roll[0] ? REQ_UNKNOWN_6 : REQ_UNKNOWN_7;
        end
        return r;
    endfunction

    // Presents one request and holds it until the transfer; the reply owed is queued
    // at the transfer edge. Valid is left high so a back-to-back request needs no dip.
    task automatic send_req(input gbt_req_t r, input logic typed, input gbt_rsp_t want);
        int       idle;
        gbt_rsp_t owed;
        idle = (steady_tx || $urandom_range(0, 99) < 60) ? 0 : pause_len();
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_payload <= r;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        owed = apply_edit(r);
        if (typed) owed = want;
        edit_replies.push_back(owed);
        req_seen[r.req_type]++;
        status_seen[owed.status]++;
    endtask

    // Sender backs off until every owed reply has come back.
    task automatic drain_replies();
        s_valid <= 1'b0;
        do @(posedge aclk); while (edit_replies.size() != 0);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_reply(input gbt_rsp_t got);
        gbt_rsp_t want;
        if (edit_replies.size() == 0) begin
            $error("reply with nothing owed: char_out %0d status %0d length %0d gap %0d",
                   got.char_out, got.status, got.text_length, got.gap_index);
            mismatches++;
        end else begin
            want = edit_replies.pop_front();
            check_field("char_out", want.char_out, got.char_out);
            check_field("status", want.status, got.status);
            check_field("text_length", want.text_length, got.text_length);
            check_field("gap_index", want.gap_index, got.gap_index);
        end
    endtask

    // Result side: check every transfer, then choose ready for the next cycle.
    // Stalls come in runs so they land on every phase of a request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) check_reply(m_payload);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!steady_rx && $urandom_range(0, 99) < 30) begin
                stall_left = pause_len() - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: any transfer on either side restarts the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d replies owed",
                     quiet_cycles, edit_replies.size());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int       k;
        int       phase;
        int       sweep [4];
        gbt_req_t r;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_payload = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Scripted edits: empty-text range checks, zero counts, unknown codes,
        // gap moves with reads across the gap, and a stale iterator.
        foreach (SCRIPT[i]) send_req(SCRIPT[i].req, SCRIPT[i].typed, SCRIPT[i].want);
        drain_replies();

        for (k = 0; k < EDITS_RANDOM; k++) begin
            // rotate through idle patterns: both idle, steady sender, steady receiver, neither
            if (k % 128 == 0) begin
                phase = (k / 128) % 4;
                steady_tx <= (phase == 1 || phase == 3);
                steady_rx <= (phase >= 2);
            end
            if (k == CALM_AT) drain_replies();
            if (k == FILL_AT) begin
                // Fill the store completely, hit the full case, then sweep the gap
                // over the whole text in both directions with extreme counts.
                drain_replies();
                while (text_len() < BYTES) begin
                    r = pick_edit();
                    r.req_type = REQ_INSERT;
                    send_req(r, 1'b0, '0);
                end
                repeat (4) begin
                    r = pick_edit();
                    r.req_type = REQ_INSERT;
                    send_req(r, 1'b0, '0);
                end
                sweep = '{0, BYTES, -BYTES, BYTES / 2};
                sweep[0] = -gap_lo;
                foreach (sweep[j]) begin
                    r = pick_edit();
                    r.req_type    = REQ_MOVE;
                    r.shift_count = 12'(sweep[j]);
                    send_req(r, 1'b0, '0);
                end
                r = pick_edit();
                r.req_type = REQ_READ;
                r.position = '1;
                send_req(r, 1'b0, '0);
                r.req_type = REQ_NEXT;
                send_req(r, 1'b0, '0);
            end
            send_req(pick_edit(), 1'b0, '0);
        end

        drain_replies();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("edits: insert %0d, delete %0d, move %0d, read %0d, next %0d, prev %0d, bad %0d",
                 req_seen[REQ_INSERT], req_seen[REQ_DELETE], req_seen[REQ_MOVE],
                 req_seen[REQ_READ], req_seen[REQ_NEXT], req_seen[REQ_PREV],
                 req_seen[REQ_UNKNOWN_6] + req_seen[REQ_UNKNOWN_7]);
        $display("replies: ok %0d, out of range %0d, full %0d; mismatches %0d",
                 status_seen[STATUS_OK], status_seen[STATUS_RANGE],
                 status_seen[STATUS_FULL], mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
